### src/csimb_pkg.sv
// Shared widths, constants and handshake types for the channel-state magnitude binner.
package csimb_pkg;

  // Default sizes of the block.
  localparam int unsigned NUM_BINS_DEF  = 6;
  localparam int unsigned MAX_PAIRS_DEF = 256;

  // Field widths fixed by the stream format.
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned PAIRS_W   = 9;
  localparam int unsigned BIN_NUM_W = 3;
  localparam int unsigned LEVEL_W   = 8;

  // Datapath widths.
  localparam int unsigned SQ_W   = 16;  // sum of two squares, at most 32768
  localparam int unsigned RT_W   = 17;  // working width of the square root
  localparam int unsigned SUM_W  = 16;  // saturating magnitude sum
  localparam int unsigned CNT_W  = 9;   // saturating pair count
  localparam int unsigned POS_W  = 9;   // pair position, below the largest pair count
  localparam int unsigned DIV_W  = 16;  // dividend and quotient width
  localparam int unsigned DVS_W  = 9;   // divisor width
  localparam int unsigned STEP_W = 4;   // divider step counter, one bit per step

  // Padded stream widths.
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 16;

  // Request to the shared divider.
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [DVS_W-1:0]   divisor;
  } div_req_t;

  // Answer from the shared divider; done stays high until the next start.
  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quotient;
  } div_rsp_t;

endpackage

### src/csi_magnitude_binner_top.sv
// Magnitude binner top level: sequencer, bin accumulators and output register.
// A pair is taken only while the sequencer is idle; it first forms the squares, then the
// shared divider finds the bin (the square root runs alongside); once both are done the
// pair is accumulated and the sequencer goes idle. After the last pair each bin has the
// divider form its average (skipped for an empty bin), then waits out any output stall.
// Reset (rst_ni low, asynchronous) clears the position, all sums and counts and the output valid.
module csi_magnitude_binner_top
  import csimb_pkg::*;
#(
  parameter int unsigned NUM_BINS  = NUM_BINS_DEF,
  parameter int unsigned MAX_PAIRS = MAX_PAIRS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [7:0] imag_sample, [15:8] real_sample, [24:16] frame_pairs, rest zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [2:0] bin_number, [10:3] bin_level, rest zero
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // final_bin
  output logic                 m_axis_tlast_o
);

  localparam int unsigned IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);
  localparam logic [PAIRS_W+1:0] MAX_N = (PAIRS_W + 2)'(MAX_PAIRS);

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQ    = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_LVL   = 3'd4;
  localparam logic [2:0] ST_LWAIT = 3'd5;
  localparam logic [2:0] ST_PUSH  = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SAMPLE_W-1:0] im_abs_q, re_abs_q;
  logic [PAIRS_W-1:0]  n_q;
  logic [SUM_W-1:0]    sum_q [NUM_BINS];
  logic [CNT_W-1:0]    cnt_q [NUM_BINS];
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic                m_valid_q;
  logic [IDX_W-1:0]    m_idx_q;
  logic [LEVEL_W-1:0]  m_level_q;
  logic                m_last_q;

  logic                s_fire;
  logic [SAMPLE_W-1:0] im_raw, re_raw, im_abs, re_abs;
  logic [PAIRS_W-1:0]  n_raw, n_sane;
  logic [SQ_W-1:0]     radicand;
  logic                sq_start;
  logic                sq_done;
  logic [LEVEL_W-1:0]  mag;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [IDX_W-1:0]    bin_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic [SUM_W-1:0]    rd_sum;
  logic [CNT_W-1:0]    rd_cnt;
  logic [SUM_W:0]      sum_ext;
  logic                acc_we;
  logic                clr_we;
  logic                push;
  logic                is_last_pair;
  logic [IDX_W+2:0]    idx_ext;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // Absolute values and a pair count forced into 1..MAX_PAIRS.
  always_comb begin
    im_raw = s_axis_tdata_i[SAMPLE_W-1:0];
    re_raw = s_axis_tdata_i[2*SAMPLE_W-1:SAMPLE_W];
    n_raw  = s_axis_tdata_i[2*SAMPLE_W+PAIRS_W-1:2*SAMPLE_W];
    im_abs = im_raw[SAMPLE_W-1] ? (~im_raw + SAMPLE_W'(1)) : im_raw;
    re_abs = re_raw[SAMPLE_W-1] ? (~re_raw + SAMPLE_W'(1)) : re_raw;
    if (n_raw == '0) begin
      n_sane = PAIRS_W'(1);
    end else if ({2'b00, n_raw} > MAX_N) begin
      n_sane = MAX_N[PAIRS_W-1:0];
    end else begin
      n_sane = n_raw;
    end
  end

  // Note that an absolute value of 128 reads as 0x80, unsigned, which is correct.
  assign radicand = SQ_W'(im_abs_q) * SQ_W'(im_abs_q) + SQ_W'(re_abs_q) * SQ_W'(re_abs_q);
  assign sq_start = (state_q == ST_SQ);

  csimb_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (radicand),
    .done_o     (sq_done),
    .root_o     (mag)
  );

  // The divider finds the bin of a pair, then the average of each non-empty bin.
  always_comb begin
    div_req = '0;
    if (state_q == ST_SQ) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'(pos_q * NUM_BINS);
      div_req.divisor  = n_q;
    end else if ((state_q == ST_LVL) && (rd_cnt != '0)) begin
      div_req.start    = 1'b1;
      div_req.dividend = rd_sum;
      div_req.divisor  = rd_cnt;
    end
  end

  csimb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Bin index, clamped to the last bin.
  assign bin_idx = (div_rsp.quotient >= DIV_W'(NUM_BINS)) ? LAST_IDX
                                                          : div_rsp.quotient[IDX_W-1:0];
  assign rd_idx  = (state_q == ST_ACC) ? bin_idx : idx_q;
  assign rd_sum  = sum_q[rd_idx];
  assign rd_cnt  = cnt_q[rd_idx];
  assign sum_ext = {1'b0, rd_sum} + (SUM_W + 1)'(mag);
  assign is_last_pair = ({1'b0, pos_q} + (POS_W + 1)'(1)) >= (POS_W + 1)'(n_q);
  assign push    = (state_q == ST_PUSH) && (!m_valid_q || m_axis_tready_i);
  assign acc_we  = (state_q == ST_ACC);
  assign clr_we  = push;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    level_d = level_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        if (sq_done && div_rsp.done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (is_last_pair) begin
          pos_d   = '0;
          idx_d   = '0;
          state_d = ST_LVL;
        end else begin
          pos_d   = pos_q + POS_W'(1);
          state_d = ST_IDLE;
        end
      end
      ST_LVL: begin
        if (rd_cnt == '0) begin
          level_d = LEVEL_W'(1);
          state_d = ST_PUSH;
        end else begin
          state_d = ST_LWAIT;
        end
      end
      ST_LWAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient == '0) begin
            level_d = LEVEL_W'(1);
          end else if (div_rsp.quotient > DIV_W'({LEVEL_W{1'b1}})) begin
            level_d = '1;
          end else begin
            level_d = div_rsp.quotient[LEVEL_W-1:0];
          end
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push) begin
          if (idx_q == LAST_IDX) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_LVL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers and the bin accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      idx_q   <= '0;
      for (int i = 0; i < NUM_BINS; i++) begin
        sum_q[i] <= '0;
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      if (acc_we) begin
        sum_q[rd_idx] <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        if (rd_cnt != '1) begin
          cnt_q[rd_idx] <= rd_cnt + CNT_W'(1);
        end
      end else if (clr_we) begin
        sum_q[rd_idx] <= '0;
        cnt_q[rd_idx] <= '0;
      end
    end
  end

  // Captured pair payload, and the level register.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      im_abs_q <= im_abs;
      re_abs_q <= re_abs;
      n_q      <= n_sane;
    end
    level_q <= level_d;
  end

  // Output register: a result waits here until its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (push) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      m_idx_q   <= idx_q;
      m_level_q <= level_q;
      m_last_q  <= (idx_q == LAST_IDX);
    end
  end

  assign idx_ext         = {3'b000, m_idx_q};
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W - BIN_NUM_W - LEVEL_W){1'b0}}, m_level_q,
                            idx_ext[BIN_NUM_W-1:0]};
  assign m_axis_tlast_o  = m_last_q;

endmodule

### src/csimb_sqrt.sv
// Iterative floor square root, two bits of the radicand per cycle.
module csimb_sqrt
  import csimb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   radicand_i,
  output logic              done_o,
  output logic [LEVEL_W-1:0] root_o
);

  logic [RT_W-1:0] x_q, x_d;
  logic [RT_W-1:0] root_q, root_d;
  logic [2:0]      step_q, step_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [RT_W-1:0] bit_v;
  logic [RT_W-1:0] trial;

  // One digit step: compare against root plus the current bit weight.
  always_comb begin
    bit_v  = RT_W'(1) << {step_q, 1'b0};
    trial  = root_q + bit_v;
    x_d    = x_q;
    root_d = root_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      x_d    = RT_W'(radicand_i);
      root_d = '0;
      step_d = 3'd7;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_d    = x_q - trial;
        root_d = (root_q >> 1) + bit_v;
      end else begin
        root_d = root_q >> 1;
      end
      if (step_q == 3'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 3'd1;
      end
    end
  end

  // Control flags take reset; the working registers need none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[LEVEL_W-1:0];

endmodule

### src/csimb_div.sv
// Shared restoring divider, one quotient bit per cycle.
module csimb_div
  import csimb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quot_q, quot_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              ge;

  // Shift one dividend bit into the remainder and try a subtraction.
  always_comb begin
    trial  = {rem_q, quot_q[DIV_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (req_i.start) begin
      rem_d  = '0;
      quot_d = req_i.dividend;
      dvs_d  = req_i.divisor;
      step_d = STEP_W'(DIV_W - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quot_d = {quot_q[DIV_W-2:0], ge};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule
